@@ hw/rtl/afsp_pkg.sv @@
package afsp_pkg;

  // Default channel count of the converter frame
  localparam int unsigned CHANNELS = 8;

  // Queue depth between front and back
  localparam int unsigned JOB_DEPTH = 2;

  localparam int unsigned STATUS_W = 9;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned OFFSET_W = 5;
  localparam int unsigned VALUE_W  = 16;

  // Register offsets of the publish run
  localparam logic [OFFSET_W-1:0] REG_STATUS  = 5'd4;
  localparam logic [OFFSET_W-1:0] REG_SAMPLE0 = 5'd5;
  localparam logic [OFFSET_W-1:0] REG_COUNT   = 5'h15;

  // Input commands
  typedef enum logic [1:0] {
    CMD_BYTE      = 2'd0,
    CMD_PULSE     = 2'd1,
    CMD_STATUS_RD = 2'd2,
    CMD_COUNT_RD  = 2'd3
  } cmd_e;

  // One unit of back-end work
  typedef struct packed {
    logic               zero_write;  // leading count-zero write
    logic               publish;     // full snapshot run
    logic [COUNT_W-1:0] count;       // count value for the run's final write
  } job_t;

endpackage

@@ hw/rtl/afsp_front.sv @@
module afsp_front #(
  parameter int unsigned Channels = afsp_pkg::CHANNELS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          command_i,
  input  logic [7:0]                          data_byte_i,
  output logic                                push_o,
  output afsp_pkg::job_t                      job_o,
  input  logic                                full_i,
  input  logic                                busy_i,
  output logic [Channels-1:0][7:0]            hdr_o,
  output logic [Channels-1:0][23:0]           smp_o,
  output logic [afsp_pkg::STATUS_W-1:0]       status_o
);
  import afsp_pkg::*;

  localparam int unsigned FrameBytes = 4 * Channels;
  localparam int unsigned PosW       = $clog2(FrameBytes);

  typedef enum logic [1:0] {
    MODE_READY    = 2'd0,
    MODE_FROZEN   = 2'd1,
    MODE_DIVERTED = 2'd2
  } mode_e;

  logic [PosW-1:0]              pos_q;
  logic [1:0]                   pulses_q;
  logic [COUNT_W-1:0]           fc_q, pc_q;
  mode_e                        mode_q;
  logic [FrameBytes-2:0][7:0]   sr_q;
  logic [Channels-1:0][7:0]     hdr_q, hdr_d;
  logic [Channels-1:0][23:0]    smp_q, smp_d;
  logic [STATUS_W-1:0]          status_q, status_d;
  logic [FrameBytes-1:0][7:0]   frame;
  logic [COUNT_W-1:0]           fc_inc, fc_sub;
  cmd_e                         cmd;
  logic                         accept, frame_end, needs_job;

  assign cmd       = cmd_e'(command_i);
  assign frame_end = (cmd == CMD_BYTE) && (pos_q == PosW'(FrameBytes - 1));
  assign needs_job = (frame_end && (mode_q == MODE_READY)) || (cmd == CMD_COUNT_RD);

  // A frame end rewrites the snapshot, so it waits until the back is drained
  assign in_ready_o = !(frame_end && busy_i) && !(needs_job && full_i);
  assign accept     = in_valid_i && in_ready_o;

  assign fc_inc = fc_q + COUNT_W'(1);
  assign fc_sub = (pc_q <= fc_q) ? (fc_q - pc_q) : '0;

  // Assemble the frame: newest byte from the port, the rest from the shift line
  always_comb begin
    frame[FrameBytes-1] = data_byte_i;
    for (int j = 0; j < FrameBytes - 1; j++) begin
      frame[j] = sr_q[FrameBytes-2-j];
    end
  end

  // Decode headers, samples and status at frame end
  always_comb begin
    status_d    = '0;
    status_d[8] = (pulses_q > 2'd1);
    for (int i = 0; i < Channels; i++) begin
      hdr_d[i] = frame[4*i];
      smp_d[i] = {frame[4*i+1], frame[4*i+2], frame[4*i+3]};
      status_d[i] = (frame[4*i][6:4] != 3'(i));
    end
  end

  // Job for the back end
  always_comb begin
    job_o.zero_write = (cmd == CMD_COUNT_RD);
    job_o.publish    = frame_end ? 1'b1 : (mode_q == MODE_DIVERTED);
    job_o.count      = frame_end ? fc_inc : fc_sub;
  end
  assign push_o = accept && needs_job;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      pulses_q <= '0;
      fc_q     <= '0;
      pc_q     <= '0;
      mode_q   <= MODE_READY;
    end else if (accept) begin
      unique case (cmd)
        CMD_BYTE: begin
          if (frame_end) begin
            pos_q    <= '0;
            pulses_q <= '0;
            fc_q     <= fc_inc;
            if (mode_q == MODE_READY) begin
              pc_q <= fc_inc;
            end else begin
              mode_q <= MODE_DIVERTED;
            end
          end else begin
            pos_q <= pos_q + PosW'(1);
          end
        end
        CMD_PULSE: begin
          if (pulses_q != 2'd2) begin
            pulses_q <= pulses_q + 2'd1;
          end
        end
        CMD_STATUS_RD: begin
          mode_q <= MODE_FROZEN;
        end
        CMD_COUNT_RD: begin
          fc_q   <= fc_sub;
          pc_q   <= (mode_q == MODE_DIVERTED) ? fc_sub : '0;
          mode_q <= MODE_READY;
        end
        default: begin
          mode_q <= mode_q;
        end
      endcase
    end
  end

  // Byte shift line and snapshot
  always_ff @(posedge clk_i) begin
    if (accept && (cmd == CMD_BYTE)) begin
      sr_q <= {sr_q[FrameBytes-3:0], data_byte_i};
      if (frame_end) begin
        hdr_q    <= hdr_d;
        smp_q    <= smp_d;
        status_q <= status_d;
      end
    end
  end

  assign hdr_o    = hdr_q;
  assign smp_o    = smp_q;
  assign status_o = status_q;

`ifndef ASSERT_OFF
  a_frame_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && frame_end) |-> !busy_i)
    else $error("frame end accepted while back end busy");
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("job pushed into full queue");
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd == CMD_STATUS_RD)) |=> (mode_q == MODE_FROZEN))
    else $error("status read did not freeze");
`endif

endmodule

@@ hw/rtl/afsp_queue.sv @@
module afsp_queue #(
  parameter int unsigned Depth = afsp_pkg::JOB_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  afsp_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output afsp_pkg::job_t pop_data_o,
  output logic           empty_o
);
  import afsp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
  a_push_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("push did not grow queue");
`endif

endmodule

@@ hw/rtl/afsp_back.sv @@
module afsp_back #(
  parameter int unsigned Channels = afsp_pkg::CHANNELS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  afsp_pkg::job_t                    job_i,
  input  logic                              empty_i,
  output logic                              pop_o,
  output logic                              busy_o,
  input  logic [Channels-1:0][7:0]          hdr_i,
  input  logic [Channels-1:0][23:0]         smp_i,
  input  logic [afsp_pkg::STATUS_W-1:0]     status_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [afsp_pkg::OFFSET_W-1:0]     reg_offset_o,
  output logic [afsp_pkg::VALUE_W-1:0]      reg_value_o,
  output logic                              last_of_run_o
);
  import afsp_pkg::*;

  // Step 0: count-zero write, 1: status, 2..2C+1: sample words, 2C+2: count
  localparam int unsigned LastStep = 2 * Channels + 2;
  localparam int unsigned StepW    = $clog2(LastStep + 1);
  localparam int unsigned ChW      = (Channels > 1) ? $clog2(Channels) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e              state_q;
  job_t                job_q;
  logic [StepW-1:0]    step_q, k;
  logic [ChW-1:0]      ch;
  logic                out_valid_q, last_q, emit, last;
  logic [OFFSET_W-1:0] offset_q, offset;
  logic [VALUE_W-1:0]  value_q, value;

  assign pop_o  = (state_q == ST_IDLE) && !empty_i;
  assign busy_o = (state_q == ST_RUN) || !empty_i;
  assign emit   = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);

  // Word for the current step
  assign k  = step_q - StepW'(2);
  assign ch = k[ChW:1];
  always_comb begin
    priority if (step_q == '0) begin
      offset = REG_COUNT;
      value  = '0;
    end else if (step_q == StepW'(1)) begin
      offset = REG_STATUS;
      value  = VALUE_W'(status_i);
    end else if (step_q == StepW'(LastStep)) begin
      offset = REG_COUNT;
      value  = job_q.count;
    end else begin
      offset = REG_SAMPLE0 + OFFSET_W'(k);
      value  = k[0] ? {hdr_i[ch], smp_i[ch][23:16]} : smp_i[ch][15:0];
    end
  end
  assign last = job_q.publish ? (step_q == StepW'(LastStep)) : 1'b1;

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      offset_q    <= '0;
      value_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        offset_q    <= offset;
        value_q     <= value;
        last_q      <= last;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            state_q <= ST_RUN;
            job_q   <= job_i;
            step_q  <= job_i.zero_write ? '0 : StepW'(1);
          end
        end
        ST_RUN: begin
          if (emit) begin
            if (last) begin
              state_q <= ST_IDLE;
            end else begin
              step_q <= step_q + StepW'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign reg_offset_o  = offset_q;
  assign reg_value_o   = value_q;
  assign last_of_run_o = last_q;

`ifndef ASSERT_OFF
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q <= StepW'(LastStep)))
    else $error("step beyond end of run");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == ST_RUN))
    else $error("pop did not start a run");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last) |=> (state_q == ST_IDLE && out_valid_q && last_q))
    else $error("run did not end on last word");
`endif

endmodule

@@ hw/rtl/adc_frame_snapshot_publisher_unit.sv @@
// ADC frame snapshot publisher.
// Input channel (in_valid_i/in_ready_o) takes one command word per accept:
// a frame byte, a data-ready pulse, a host status read or a host count read.
// Output channel (out_valid_o/out_ready_i) gives register writes: offset,
// 16-bit value and a last flag on the final write of each run.
// A front stage takes each accepted word and updates the frame shift
// line, pulse counter, frame count and snapshot mode. Work that produces
// writes goes into a two-entry job queue; a back sequencer turns each job
// into writes through an output register, one per cycle while unstalled.
// A full publish run is 18 writes (19 after a count read). With no stall
// a job passes through the queue, the sequencer and the output register,
// and its writes follow one per cycle; the sequencer returns to idle between queued jobs.
// The last byte of a frame is held off until the queue and sequencer are
// empty, since it rewrites the snapshot the sequencer reads. A count read
// waits while the queue is full; all other words keep flowing while a run
// drains. A stalled receiver holds the output word and backs up the queue
// and then the input channel. After reset: frame position and counts are
// zero and the mode is ready; both channels are idle.
module adc_frame_snapshot_publisher_unit #(
  parameter int unsigned Channels = afsp_pkg::CHANNELS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    command_i,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [afsp_pkg::OFFSET_W-1:0] reg_offset_o,
  output logic [afsp_pkg::VALUE_W-1:0]  reg_value_o,
  output logic                          last_of_run_o
);
  import afsp_pkg::*;

  job_t                      push_job, pop_job;
  logic                      push, pop, full, empty, busy;
  logic [Channels-1:0][7:0]  hdr;
  logic [Channels-1:0][23:0] smp;
  logic [STATUS_W-1:0]       status;

  // Accept and classify
  afsp_front #(
    .Channels (Channels)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .job_o       (push_job),
    .full_i      (full),
    .busy_i      (busy),
    .hdr_o       (hdr),
    .smp_o       (smp),
    .status_o    (status)
  );

  // Job queue
  afsp_queue #(
    .Depth (JOB_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  // Write sequencer
  afsp_back #(
    .Channels (Channels)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (pop_job),
    .empty_i       (empty),
    .pop_o         (pop),
    .busy_o        (busy),
    .hdr_i         (hdr),
    .smp_i         (smp),
    .status_i      (status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .reg_offset_o  (reg_offset_o),
    .reg_value_o   (reg_value_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
